>>> hw/rtl/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// Shared types, widths and codes for the light priority selector.
// ---------------------------------------------------------------------------
package lps_pkg;

    // Default number of kept slots per store.
    localparam int SLOTS_DEF = 16;

    // At most this many results are sent per list.
    localparam int MAX_RES = 16;
    localparam int FOUND_W = $clog2(MAX_RES + 1);

    // Field widths.
    localparam int ID_W    = 16;
    localparam int TYPE_W  = 2;
    localparam int COORD_W = 24;
    localparam int DIST_W  = 25;
    localparam int KEY_W   = 27;
    localparam int SLOT_W  = 4;

    // Number of root digits produced by the square root unit.
    localparam int SQRT_STEPS = 25;

    // Light type codes.
    localparam logic [TYPE_W-1:0] TYPE_DIR   = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_POINT = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_SPOT  = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_OTHER = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CAM_X = 2'd0;
    localparam logic [1:0] REG_CAM_Y = 2'd1;
    localparam logic [1:0] REG_CAM_Z = 2'd2;

    // One entry of the ranked store.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
        logic [TYPE_W-1:0]       ltype;
    } ent_t;

    // Command from the front end to the store sequencer.
    typedef struct packed {
        logic                    valid;
        logic                    is_dir;
        logic                    last_flag;
        logic [ID_W-1:0]         id;
        logic [TYPE_W-1:0]       ltype;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

endpackage

>>> hw/rtl/lps_dist.sv
// ---------------------------------------------------------------------------
// lps_dist
// Euclidean distance unit: one shared multiplier for the three squares,
// then a digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module lps_dist
    import lps_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] cam_x,
    input  logic signed [COORD_W-1:0] cam_y,
    input  logic signed [COORD_W-1:0] cam_z,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    output logic                      done,
    output logic [DIST_W-1:0]         root_out
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_SQRT = 4'b0100,
        D_DONE = 4'b1000
    } dstate_t;

    dstate_t             state_reg, state_next;
    logic [1:0]          ax_reg, ax_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [2*DIST_W-1:0] prod_reg, prod_next;
    logic [2*DIST_W-1:0] acc_reg, acc_next;
    logic [28:0]         rem_reg, rem_next;
    logic [DIST_W-1:0]   q_reg, q_next;

    logic signed [COORD_W-1:0] cam_sel, pos_sel;
    logic signed [DIST_W-1:0]  diff;
    logic [DIST_W-1:0]         mag;
    logic [28:0]               rem_sh, trial;

    // Pick the axis for the shared multiplier.
    always_comb begin
        unique case (ax_reg)
            2'd0:    begin cam_sel = cam_x; pos_sel = pos_x; end
            2'd1:    begin cam_sel = cam_y; pos_sel = pos_y; end
            default: begin cam_sel = cam_z; pos_sel = pos_z; end
        endcase
        diff = DIST_W'(cam_sel) - DIST_W'(pos_sel);
        mag  = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    end

    // One root digit: shift in two bits of the radicand and try a subtract.
    assign rem_sh = {rem_reg[26:0], acc_reg[2*DIST_W-1 -: 2]};
    assign trial  = {2'b00, q_reg, 2'b01};

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    ax_next    = 2'd0;
                    acc_next   = '0;
                    state_next = D_MUL;
                end
            end
            D_MUL: begin
                prod_next = mag * mag;
                if (ax_reg != 2'd0) begin
                    acc_next = acc_reg + prod_reg;
                end
                if (ax_reg == 2'd3) begin
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = D_SQRT;
                end else begin
                    ax_next = ax_reg + 2'd1;
                end
            end
            D_SQRT: begin
                acc_next = acc_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next = rem_sh - trial;
                    q_next   = {q_reg[DIST_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[DIST_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    state_next = D_DONE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            D_DONE: begin
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ax_reg   <= ax_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done     = (state_reg == D_DONE);
    assign root_out = q_reg;

endmodule

>>> hw/rtl/lps_core.sv
// ---------------------------------------------------------------------------
// lps_core
// Directional and ranked stores in synchronous memories, the ordered
// insert sweep, and the emission sequencer with its output register.
// ---------------------------------------------------------------------------
module lps_core
    import lps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output logic              idle,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_out_id,
    output logic [TYPE_W-1:0] m_out_type,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_empty_res,
    output logic              m_last_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_SCAN = 7'b0000010,
        C_TAIL = 7'b0000100,
        C_ERD  = 7'b0001000,
        C_ECHK = 7'b0010000,
        C_EEND = 7'b0100000,
        C_SPARE = 7'b1000000
    } cstate_t;

    typedef enum logic [1:0] {
        PH_DIR   = 2'd0,
        PH_SPOT  = 2'd1,
        PH_POINT = 2'd2
    } phase_t;

    // Memories.
    logic [ID_W-1:0] dir_mem  [SLOTS];
    ent_t            rank_mem [SLOTS];
    logic [ID_W-1:0] dir_q;
    ent_t            rank_q;

    logic            dir_we, rank_we;
    logic [IW-1:0]   dir_wa, rank_wa;
    logic [ID_W-1:0] dir_wd;
    ent_t            rank_wd;

    cstate_t           state_reg, state_next;
    logic [IW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     dcount_reg, dcount_next;
    logic [CW-1:0]     rcount_reg, rcount_next;
    logic [IW-1:0]     ridx_reg, ridx_next;
    ent_t              carry_reg, carry_next;
    logic              ins_reg, ins_next;
    logic              fin_reg, fin_next;
    phase_t            phase_reg, phase_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     dptr_reg, dptr_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic [ID_W-1:0]   cid_reg, cid_next;
    logic [TYPE_W-1:0] ctype_reg, ctype_next;
    logic [SLOT_W-1:0] cslot_reg, cslot_next;
    logic              cand_v_reg, cand_v_next;

    logic              ov_reg, ov_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [TYPE_W-1:0] otype_reg, otype_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic              oempty_reg, oempty_next;
    logic              olast_reg, olast_next;

    logic [CW-1:0]     avail, lim;
    logic              out_free, swap, more, hit;
    logic [ID_W-1:0]   hit_id;
    logic [TYPE_W-1:0] hit_type, want;
    ent_t              new_ent;

    // Emission limit for the ranked list.
    assign avail    = CW'(SLOTS) - dcount_reg;
    assign lim      = (avail < rcount_reg) ? avail : rcount_reg;
    assign out_free = !ov_reg || m_ready;
    assign swap     = ins_reg || (rank_q.key > carry_reg.key);
    assign want     = (phase_reg == PH_SPOT) ? TYPE_SPOT : TYPE_POINT;
    assign new_ent  = '{key: cmd.key, id: cmd.id, ltype: cmd.ltype};

    always_comb begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        dcount_next = dcount_reg;
        rcount_next = rcount_reg;
        ridx_next   = ridx_reg;
        carry_next  = carry_reg;
        ins_next    = ins_reg;
        fin_next    = fin_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        dptr_next   = dptr_reg;
        found_next  = found_reg;
        cid_next    = cid_reg;
        ctype_next  = ctype_reg;
        cslot_next  = cslot_reg;
        cand_v_next = cand_v_reg;
        ov_next     = ov_reg && !m_ready;
        oid_next    = oid_reg;
        otype_next  = otype_reg;
        oslot_next  = oslot_reg;
        oempty_next = oempty_reg;
        olast_next  = olast_reg;
        dir_we      = 1'b0;
        dir_wa      = wp_reg;
        dir_wd      = cmd.id;
        rank_we     = 1'b0;
        rank_wa     = ridx_reg;
        rank_wd     = carry_reg;
        more        = 1'b0;
        hit         = 1'b0;
        hit_id      = dir_q;
        hit_type    = TYPE_DIR;

        unique case (state_reg)
            C_IDLE: begin
                if (cmd.valid) begin
                    fin_next = cmd.last_flag;
                    if (cmd.is_dir) begin
                        // Ring buffer: newest entry sits just behind the pointer.
                        dir_we  = 1'b1;
                        wp_next = (wp_reg == IW'(SLOTS - 1)) ? '0 : wp_reg + IW'(1);
                        if (dcount_reg != CW'(SLOTS)) begin
                            dcount_next = dcount_reg + CW'(1);
                        end
                        if (cmd.last_flag) begin
                            state_next = C_ERD;
                        end
                    end else if (rcount_reg == '0) begin
                        rank_we     = 1'b1;
                        rank_wa     = '0;
                        rank_wd     = new_ent;
                        rcount_next = CW'(1);
                        if (cmd.last_flag) begin
                            state_next = C_ERD;
                        end
                    end else begin
                        carry_next = new_ent;
                        ins_next   = 1'b0;
                        ridx_next  = '0;
                        state_next = C_SCAN;
                    end
                    // Set up the emission walk.
                    phase_next  = PH_DIR;
                    cnt_next    = '0;
                    found_next  = '0;
                    cand_v_next = 1'b0;
                    dptr_next   = (wp_next == '0) ? IW'(SLOTS - 1) : wp_next - IW'(1);
                end
            end
            C_SCAN: begin
                // Insert sweep: the carried entry moves down past keys no larger than its own.
                if (swap) begin
                    rank_we    = 1'b1;
                    rank_wa    = ridx_reg;
                    rank_wd    = carry_reg;
                    carry_next = rank_q;
                    ins_next   = 1'b1;
                end
                if (CW'(ridx_reg) == rcount_reg - CW'(1)) begin
                    state_next = C_TAIL;
                end else begin
                    ridx_next = ridx_reg + IW'(1);
                end
            end
            C_TAIL: begin
                if (rcount_reg != CW'(SLOTS)) begin
                    rank_we     = 1'b1;
                    rank_wa     = rcount_reg[IW-1:0];
                    rank_wd     = carry_reg;
                    rcount_next = rcount_reg + CW'(1);
                end
                state_next = fin_reg ? C_ERD : C_IDLE;
            end
            C_ERD: begin
                if (phase_reg == PH_DIR) begin
                    more = cnt_reg < dcount_reg;
                end else begin
                    more = cnt_reg < lim;
                end
                if (found_reg == FOUND_W'(MAX_RES)) begin
                    state_next = C_EEND;
                end else if (more) begin
                    state_next = C_ECHK;
                end else begin
                    cnt_next  = '0;
                    ridx_next = '0;
                    unique case (phase_reg)
                        PH_DIR:   phase_next = PH_SPOT;
                        PH_SPOT:  phase_next = PH_POINT;
                        default:  state_next = C_EEND;
                    endcase
                end
            end
            C_ECHK: begin
                if (phase_reg == PH_DIR) begin
                    hit = 1'b1;
                end else begin
                    hit      = (rank_q.ltype == want);
                    hit_id   = rank_q.id;
                    hit_type = want;
                end
                if (!(hit && cand_v_reg && !out_free)) begin
                    // Candidate is held back one step so the last can be flagged.
                    if (hit) begin
                        if (cand_v_reg) begin
                            ov_next     = 1'b1;
                            oid_next    = cid_reg;
                            otype_next  = ctype_reg;
                            oslot_next  = cslot_reg;
                            oempty_next = 1'b0;
                            olast_next  = 1'b0;
                        end
                        cid_next    = hit_id;
                        ctype_next  = hit_type;
                        cslot_next  = found_reg[SLOT_W-1:0];
                        cand_v_next = 1'b1;
                        found_next  = found_reg + FOUND_W'(1);
                    end
                    cnt_next = cnt_reg + CW'(1);
                    if (phase_reg == PH_DIR) begin
                        dptr_next = (dptr_reg == '0) ? IW'(SLOTS - 1) : dptr_reg - IW'(1);
                    end else begin
                        ridx_next = ridx_reg + IW'(1);
                    end
                    state_next = C_ERD;
                end
            end
            C_EEND: begin
                if (out_free) begin
                    ov_next     = 1'b1;
                    oid_next    = cand_v_reg ? cid_reg : '0;
                    otype_next  = cand_v_reg ? ctype_reg : TYPE_DIR;
                    oslot_next  = cand_v_reg ? cslot_reg : '0;
                    oempty_next = !cand_v_reg;
                    olast_next  = 1'b1;
                    wp_next     = '0;
                    dcount_next = '0;
                    rcount_next = '0;
                    state_next  = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Memory ports: one write, one registered read each.
    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_wa] <= dir_wd;
        end
        dir_q <= dir_mem[dptr_next];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_q <= rank_mem[ridx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            wp_reg     <= '0;
            dcount_reg <= '0;
            rcount_reg <= '0;
            cand_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            dcount_reg <= dcount_next;
            rcount_reg <= rcount_next;
            cand_v_reg <= cand_v_next;
            ov_reg     <= ov_next;
        end
        ridx_reg   <= ridx_next;
        carry_reg  <= carry_next;
        ins_reg    <= ins_next;
        fin_reg    <= fin_next;
        phase_reg  <= phase_next;
        cnt_reg    <= cnt_next;
        dptr_reg   <= dptr_next;
        found_reg  <= found_next;
        cid_reg    <= cid_next;
        ctype_reg  <= ctype_next;
        cslot_reg  <= cslot_next;
        oid_reg    <= oid_next;
        otype_reg  <= otype_next;
        oslot_reg  <= oslot_next;
        oempty_reg <= oempty_next;
        olast_reg  <= olast_next;
    end

    assign idle        = (state_reg == C_IDLE);
    assign m_valid     = ov_reg;
    assign m_out_id    = oid_reg;
    assign m_out_type  = otype_reg;
    assign m_slot      = oslot_reg;
    assign m_empty_res = oempty_reg;
    assign m_last_out  = olast_reg;

endmodule

>>> hw/rtl/light_priority_selector.sv
// ---------------------------------------------------------------------------
// light_priority_selector
// Picks the lights for one frame: directional lights newest first, then
// the nearest spot and point lights ranked by distance minus range.
//
//   Channel  Direction  Handshake         Word
//   s_       in         s_valid/s_ready   one light
//   m_       out        m_valid/m_ready   one selected light
//   APB      in         psel/penable      camera x, y, z
//
// A directional light goes straight to the directional store. Any other
// light first passes the distance unit: a start step, the shared
// multiplier, the root bits and a step to finish the root; then the key
// is handed over and an insert sweep runs over the stored ranked entries,
// unless that store is empty. The next light is accepted only after
// that. The last light also starts emission, which walks the stored
// entries, changes phase and ends with a closing word, and can be held
// by output stalls. Reset is synchronous and empties both stores at once.
// ---------------------------------------------------------------------------
module light_priority_selector
    import lps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ID_W-1:0]           s_light_id,
    input  logic [TYPE_W-1:0]         s_light_type,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic [COORD_W-1:0]        s_reach,
    input  logic                      s_final_light,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ID_W-1:0]           m_out_id,
    output logic [TYPE_W-1:0]         m_out_type,
    output logic [SLOT_W-1:0]         m_slot,
    output logic                      m_empty_res,
    output logic                      m_last_out
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_DIST = 3'b010,
        T_CMD  = 3'b100
    } tstate_t;

    tstate_t                   state_reg, state_next;
    logic signed [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [ID_W-1:0]           id_reg;
    logic [TYPE_W-1:0]         type_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COORD_W-1:0]        reach_reg;
    logic                      fin_reg;
    logic signed [KEY_W-1:0]   key_reg;

    logic              apb_wr, s_fire, core_idle, dist_done;
    logic [DIST_W-1:0] root_val;
    logic [COORD_W-1:0] rd_val;
    cmd_t              cmd;

    // Camera registers on the configuration port.
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end else if (apb_wr) begin
            unique case (paddr[3:2])
                REG_CAM_X: cam_x_reg <= pwdata[COORD_W-1:0];
                REG_CAM_Y: cam_y_reg <= pwdata[COORD_W-1:0];
                REG_CAM_Z: cam_z_reg <= pwdata[COORD_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CAM_X: rd_val = cam_x_reg;
            REG_CAM_Y: rd_val = cam_y_reg;
            REG_CAM_Z: rd_val = cam_z_reg;
            default:   rd_val = '0;
        endcase
        prdata = {{(32 - COORD_W){rd_val[COORD_W-1]}}, rd_val};
    end

    // Input acceptance and front-end sequencing.
    assign s_ready = (state_reg == T_IDLE) && core_idle;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_fire) begin
                    state_next = (s_light_type == TYPE_DIR) ? T_CMD : T_DIST;
                end
            end
            T_DIST: begin
                if (dist_done) begin
                    state_next = T_CMD;
                end
            end
            T_CMD: begin
                state_next = T_IDLE;
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (s_fire) begin
            id_reg    <= s_light_id;
            type_reg  <= s_light_type;
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            pz_reg    <= s_pos_z;
            reach_reg <= s_reach;
            fin_reg   <= s_final_light;
        end
        // Key is distance minus range.
        if (dist_done) begin
            key_reg <= $signed({2'b00, root_val}) - $signed({3'b000, reach_reg});
        end
    end

    lps_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == T_DIST),
        .cam_x    (cam_x_reg),
        .cam_y    (cam_y_reg),
        .cam_z    (cam_z_reg),
        .pos_x    (px_reg),
        .pos_y    (py_reg),
        .pos_z    (pz_reg),
        .done     (dist_done),
        .root_out (root_val)
    );

    assign cmd = '{valid:     (state_reg == T_CMD),
                   is_dir:    (type_reg == TYPE_DIR),
                   last_flag: fin_reg,
                   id:        id_reg,
                   ltype:     type_reg,
                   key:       key_reg};

    lps_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .idle        (core_idle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_id    (m_out_id),
        .m_out_type  (m_out_type),
        .m_slot      (m_slot),
        .m_empty_res (m_empty_res),
        .m_last_out  (m_last_out)
    );

endmodule

>>> sim/light_priority_selector_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// light_priority_selector_tb
// Drives sets of lights into the selector under fixed and random camera positions and
// checks every emitted word against a scoreboard that keeps its own
// directional and ranked stores and works out the list for each set.
// ---------------------------------------------------------------------------
module light_priority_selector_tb;
    import lps_pkg::*;

    localparam int NSLOTS = SLOTS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    // One expected selected light.
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] ltype;
        logic [SLOT_W-1:0] slot;
        logic              empty;
        logic              last;
    } pick_t;

    // Ranked entry of the scoreboard's own store.
    typedef struct {
        longint            key;
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] ltype;
    } rank_t;

    // Scoreboard: mirrors the selector's stores and holds pending picks.
    class light_scoreboard;
        longint cam[3];
        logic [ID_W-1:0] dir_ids[$];
        rank_t ranked[$];
        pick_t picks[$];
        int errors;

        function new();
            cam[0] = 0;
            cam[1] = 0;
            cam[2] = 0;
            errors = 0;
        endfunction

        // Append one expected word at the tail of the pending list.
        function void add_pick(pick_t p);
            picks.insert(picks.size(), p);
        endfunction

        function longint root_floor(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b = b >>> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        // Note one accepted light; on the final light build the list.
        function void note_light(logic [ID_W-1:0] id, logic [TYPE_W-1:0] lt,
                                 logic signed [COORD_W-1:0] px,
                                 logic signed [COORD_W-1:0] py,
                                 logic signed [COORD_W-1:0] pz,
                                 logic [COORD_W-1:0] rch, logic fin);
            longint d0, d1, d2, key, lim;
            int pos, n;
            rank_t e;
            pick_t p;
            if (lt == TYPE_DIR) begin
                dir_ids.push_front(id);
                if (dir_ids.size() > NSLOTS) void'(dir_ids.pop_back());
            end else begin
                d0 = cam[0] - longint'(px);
                d1 = cam[1] - longint'(py);
                d2 = cam[2] - longint'(pz);
                key = root_floor(d0 * d0 + d1 * d1 + d2 * d2) - longint'(rch);
                pos = 0;
                while (pos < ranked.size() && ranked[pos].key <= key) pos++;
                if (pos < NSLOTS) begin
                    e.key = key;
                    e.id = id;
                    e.ltype = lt;
                    ranked.insert(pos, e);
                    if (ranked.size() > NSLOTS) void'(ranked.pop_back());
                end
            end
            if (!fin) return;
            n = 0;
            foreach (dir_ids[i]) begin
                if (n < MAX_RES) begin
                    p.id = dir_ids[i];
                    p.ltype = TYPE_DIR;
                    p.slot = n[SLOT_W-1:0];
                    p.empty = 0;
                    p.last = 0;
                    add_pick(p);
                    n++;
                end
            end
            lim = NSLOTS - dir_ids.size();
            if (lim > ranked.size()) lim = ranked.size();
            // Spot lights first, then point lights, both in rank order.
            for (int ps = 0; ps < 2; ps++) begin
                for (int i = 0; i < lim; i++) begin
                    if (n < MAX_RES &&
                        ranked[i].ltype == (ps == 0 ? TYPE_SPOT : TYPE_POINT)) begin
                        p.id = ranked[i].id;
                        p.ltype = ranked[i].ltype;
                        p.slot = n[SLOT_W-1:0];
                        p.empty = 0;
                        p.last = 0;
                        add_pick(p);
                        n++;
                    end
                end
            end
            if (n == 0) begin
                p.id = 0;
                p.ltype = TYPE_DIR;
                p.slot = 0;
                p.empty = 1;
                p.last = 0;
                add_pick(p);
            end
            picks[picks.size() - 1].last = 1;
            dir_ids.delete();
            ranked.delete();
        endfunction

        // Compare one emitted word with the oldest pending pick.
        function void check_pick(logic [ID_W-1:0] id, logic [TYPE_W-1:0] lt,
                                 logic [SLOT_W-1:0] sl, logic em, logic la);
            pick_t p;
            if (picks.size() == 0) begin
                $error("unexpected word: id %0d", id);
                errors++;
                return;
            end
            p = picks.pop_front();
            if (id !== p.id) begin
                $error("out_id: expected %0d, got %0d", p.id, id);
                errors++;
            end
            if (lt !== p.ltype) begin
                $error("out_type: expected %0d, got %0d", p.ltype, lt);
                errors++;
            end
            if (sl !== p.slot) begin
                $error("slot: expected %0d, got %0d", p.slot, sl);
                errors++;
            end
            if (em !== p.empty) begin
                $error("empty_res: expected %0d, got %0d", p.empty, em);
                errors++;
            end
            if (la !== p.last) begin
                $error("last_out: expected %0d, got %0d", p.last, la);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [ID_W-1:0] s_light_id;
    logic [TYPE_W-1:0] s_light_type;
    logic signed [COORD_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic [COORD_W-1:0] s_reach;
    logic s_final_light;
    logic m_valid, m_ready;
    logic [ID_W-1:0] m_out_id;
    logic [TYPE_W-1:0] m_out_type;
    logic [SLOT_W-1:0] m_slot;
    logic m_empty_res, m_last_out;

    light_scoreboard board;
    longint cycles;
    bit hold_long;
    bit stim_done;
    int sent;

    light_priority_selector #(.SLOTS(NSLOTS)) i_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Check each word accepted on the result channel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_pick(m_out_id, m_out_type, m_slot, m_empty_res, m_last_out);
    end

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_long = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 2);
            if (cycles % 3000 < 1000) gap = 0;
            if (gap == 0) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Write one camera register over the configuration port.
    task automatic write_reg(logic [1:0] idx, logic signed [COORD_W-1:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= {{8{val[COORD_W-1]}}, val};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.cam[idx] = longint'(val);
    endtask

    // Offer one light and wait until it is accepted.
    task automatic send_light(logic [ID_W-1:0] id, logic [TYPE_W-1:0] lt,
                              logic signed [COORD_W-1:0] px,
                              logic signed [COORD_W-1:0] py,
                              logic signed [COORD_W-1:0] pz,
                              logic [COORD_W-1:0] rch, logic fin, bit gaps);
        int gap;
        if (gaps) begin
            gap = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 30)
                                               : $urandom_range(0, 2);
            if (gap != 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1;
        s_light_id <= id;
        s_light_type <= lt;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_reach <= rch;
        s_final_light <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_light(id, lt, px, py, pz, rch, fin);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (board.picks.size() != 0) @(posedge aclk);
        // Let the selector settle before the next step.
        repeat (80) @(posedge aclk);
    endtask

    // Random position: half the time near the origin, otherwise anywhere or at the extremes.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom());
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_reach();
        return $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 3000));
    endfunction

    // Random set of lights ending with the final flag.
    task automatic send_set(int n);
        logic [TYPE_W-1:0] lt;
        for (int i = 0; i < n; i++) begin
            lt = TYPE_W'($urandom_range(0, 3));
            send_light(ID_W'($urandom()), lt, rand_coord(), rand_coord(), rand_coord(),
                       rand_reach(), i == n - 1, 1);
        end
    endtask

    initial begin
        board = new();
        aresetn = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        s_valid = 0;
        s_light_id = 0;
        s_light_type = 0;
        s_pos_x = 0;
        s_pos_y = 0;
        s_pos_z = 0;
        s_reach = 0;
        s_final_light = 0;
        hold_long = 0;
        sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty list, extremes, ties, every type, overflow.
        send_light(16'h0000, TYPE_OTHER, 0, 0, 0, 0, 1, 0);
        send_light(16'hFFFF, TYPE_SPOT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                   24'hFFFFFF, 0, 0);
        send_light(16'h1234, TYPE_POINT, 24'sh800000, 24'sh800000, 24'sh800000,
                   0, 0, 0);
        send_light(16'h0001, TYPE_POINT, 100, 0, 0, 0, 0, 0);
        send_light(16'h0002, TYPE_SPOT, 100, 0, 0, 0, 0, 0);
        send_light(16'h0003, TYPE_OTHER, 0, 0, 50, 0, 0, 0);
        send_light(16'hABCD, TYPE_DIR, 24'sh555555, 24'shAAAAAA, 0, 24'h5A5A5A, 1, 0);
        drain();
        for (int i = 0; i < 18; i++)
            send_light(16'(i + 100), TYPE_DIR, 0, 0, 0, 0, i == 17, 0);
        drain();
        write_reg(REG_CAM_X, 24'sh7FFFFF);
        write_reg(REG_CAM_Y, 24'sh800000);
        write_reg(REG_CAM_Z, 24'sh7FFFFF);
        send_set(20);
        drain();

        // Random sets; fill-up under a long output hold-off.
        while (sent < 410) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_reg(REG_CAM_X, rand_coord());
                write_reg(REG_CAM_Y, rand_coord());
                write_reg(REG_CAM_Z, rand_coord());
            end
            if (sent > 150 && sent < 170) hold_long = 1;
            send_set($urandom_range(0, 4) == 0 ? $urandom_range(17, 24)
                                               : $urandom_range(1, 10));
        end
        drain();
        write_reg(REG_CAM_X, 0);
        write_reg(REG_CAM_Y, 0);
        write_reg(REG_CAM_Z, 0);
        send_set(5);
        drain();

        if (board.errors == 0 && board.picks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/lps_pkg.sv
hw/rtl/lps_dist.sv
hw/rtl/lps_core.sv
hw/rtl/light_priority_selector.sv
sim/light_priority_selector_tb.sv
